### rtl/contiguous_free_page_run_finder_unit_macros.svh
// Assertion helpers shared by the RTL. Each assertion is sampled on the
// rising edge of clk and is switched off while rst is high.
`ifndef CONTIGUOUS_FREE_PAGE_RUN_FINDER_UNIT_MACROS_SVH
`define CONTIGUOUS_FREE_PAGE_RUN_FINDER_UNIT_MACROS_SVH

// Same-cycle implication
`define CFPRF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CFPRF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cfprf_pkg.sv
package cfprf_pkg;

  localparam int PAGE_INDEX_BITS = 36;
  localparam int COUNT_BITS      = 37;
  localparam int FANOUT_SHIFT    = 9;

  // Saturated count value
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Entry sizes / search granularities
  localparam logic [1:0] LVL_4K = 2'd0;
  localparam logic [1:0] LVL_2M = 2'd1;
  localparam logic [1:0] LVL_1G = 2'd2;

  // Descriptor state codes
  localparam logic [2:0] ST_FREE    = 3'd0;
  localparam logic [2:0] ST_KERNEL  = 3'd1;
  localparam logic [2:0] ST_PERSIST = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_SPLIT   = 3'd6;

  typedef enum logic [2:0] {
    STS_FOUND       = 3'd0,
    STS_NOT_ENOUGH  = 3'd1,
    STS_MISSING_TOP = 3'd2,
    STS_MISSING_SUB = 3'd3,
    STS_ILLEGAL     = 3'd4,
    STS_4K_SUB      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ACT_SKIP,
    ACT_FREE,
    ACT_BREAK,
    ACT_FATAL
  } act_t;

  // Classifier verdict for one descriptor
  typedef struct packed {
    act_t    act;
    status_t fatal;
  } cls_t;

  typedef struct packed {
    logic                       first_entry;
    logic [1:0]                 unit;
    logic [COUNT_BITS-1:0]      pages_wanted;
    logic [1:0]                 level;
    logic [PAGE_INDEX_BITS-1:0] page_index;
    logic [2:0]                 state_code;
    logic                       has_subtable;
    logic                       buddy_owned;
    logic                       entry_missing;
    logic                       children_missing;
    logic                       last_entry;
  } req_t;

  typedef struct packed {
    status_t                    status;
    logic [PAGE_INDEX_BITS-1:0] base_page;
  } rsp_t;

  // Level or unit code 3 behaves as 1GB
  function automatic logic [1:0] sat_level(input logic [1:0] code);
    return (code == 2'd3) ? LVL_1G : code;
  endfunction

  // Weight of a free entry: FANOUT^(level - unit), diff in 0..2
  function automatic logic [COUNT_BITS-1:0] weight_of(input logic [1:0] diff);
    logic [COUNT_BITS-1:0] w;
    w = '0;
    case (diff)
      2'd0:    w[0] = 1'b1;
      2'd1:    w[FANOUT_SHIFT] = 1'b1;
      default: w[2*FANOUT_SHIFT] = 1'b1;
    endcase
    return w;
  endfunction

  // Entry size in 4KB pages
  function automatic logic [PAGE_INDEX_BITS-1:0] size_of(input logic [1:0] lvl);
    logic [PAGE_INDEX_BITS-1:0] s;
    s = '0;
    case (lvl)
      LVL_4K:  s[0] = 1'b1;
      LVL_2M:  s[FANOUT_SHIFT] = 1'b1;
      default: s[2*FANOUT_SHIFT] = 1'b1;
    endcase
    return s;
  endfunction

endpackage

### rtl/contiguous_free_page_run_finder_unit.sv
// Contiguous free page run finder. Page-map descriptors arrive on the
// request channel in address order, one per cycle while req_stall is low; a
// request with first_entry set opens a new search. Each descriptor waits in
// the input register, where the run count, address continuity and
// threshold are worked out, and a result (found, not enough or a fatal
// status) is written to the output register as the input register moves
// on. At most one result per search. The input register frees as soon
// as the output register can take its result, so req_stall follows
// rsp_stall in the same cycle only while a result waits to be taken.
`include "contiguous_free_page_run_finder_unit_macros.svh"

module contiguous_free_page_run_finder_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  cfprf_pkg::req_t  req_data,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output cfprf_pkg::rsp_t  rsp_data
);

  cfprf_pkg::req_t s1;
  logic            s1_valid;
  logic            adv;
  logic            res_valid;
  cfprf_pkg::rsp_t res;

  // Input register moves on when the output register has room
  assign adv       = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1 <= req_data;
    end
  end

  cfprf_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .item      (s1),
    .adv       (adv),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv && res_valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      rsp_data <= res;
    end
  end

  `CFPRF_ASSERT_IMP(a_no_stall_when_out_free, !rsp_valid, !req_stall, "request stalled with empty output")
  `CFPRF_ASSERT_NXT(a_result_lands, adv && res_valid, rsp_valid && (rsp_data == $past(res)), "result not registered")
  `CFPRF_ASSERT_NXT(a_request_taken, req_valid && !req_stall, s1_valid, "accepted request lost")
  `CFPRF_ASSERT_IMP(a_base_only_on_found, rsp_valid && (rsp_data.status != cfprf_pkg::STS_FOUND), rsp_data.base_page == '0, "base set without a found run")

endmodule

### rtl/cfprf_classify.sv
// Decides what one descriptor does to the current run.
module cfprf_classify (
  input  logic [1:0]       unit,
  input  logic [1:0]       level,
  input  logic [2:0]       state_code,
  input  logic             has_subtable,
  input  logic             buddy_owned,
  input  logic             entry_missing,
  input  logic             children_missing,
  output cfprf_pkg::cls_t  cls
);

  logic used;

  assign used = (state_code >= cfprf_pkg::ST_KERNEL) &&
                (state_code <= cfprf_pkg::ST_PERSIST);

  always_comb begin
    cls.act   = cfprf_pkg::ACT_FATAL;
    cls.fatal = cfprf_pkg::STS_ILLEGAL;
    if (level < unit) begin
      // finer than the search unit
      cls.act = cfprf_pkg::ACT_SKIP;
    end else if (entry_missing) begin
      if (unit == cfprf_pkg::LVL_4K) begin
        cls.fatal = cfprf_pkg::STS_MISSING_TOP;
      end else begin
        cls.act = cfprf_pkg::ACT_SKIP;
      end
    end else if (level == cfprf_pkg::LVL_4K) begin
      if (has_subtable) begin
        cls.fatal = cfprf_pkg::STS_4K_SUB;
      end else if (state_code == cfprf_pkg::ST_FREE) begin
        cls.act = cfprf_pkg::ACT_FREE;
      end else if (used || buddy_owned) begin
        cls.act = cfprf_pkg::ACT_BREAK;
      end
    end else if (!has_subtable && !buddy_owned) begin
      // atomic coarse entry
      if (state_code == cfprf_pkg::ST_FREE) begin
        cls.act = cfprf_pkg::ACT_FREE;
      end else if (used) begin
        cls.act = cfprf_pkg::ACT_BREAK;
      end else if (unit == cfprf_pkg::LVL_2M && level == cfprf_pkg::LVL_2M &&
                   state_code == cfprf_pkg::ST_SPLIT) begin
        cls.act = cfprf_pkg::ACT_BREAK;
      end
    end else if (state_code == cfprf_pkg::ST_FULL || buddy_owned) begin
      cls.act = cfprf_pkg::ACT_BREAK;
    end else if (state_code == cfprf_pkg::ST_SPLIT) begin
      if (level == unit) begin
        cls.act = cfprf_pkg::ACT_BREAK;
      end else if (children_missing) begin
        cls.fatal = cfprf_pkg::STS_MISSING_SUB;
      end else begin
        // children follow in the stream
        cls.act = cfprf_pkg::ACT_SKIP;
      end
    end
  end

endmodule

### rtl/cfprf_tracker.sv
// Run state and per-descriptor update. Works on the registered request and
// commits its new state on adv.
module cfprf_tracker (
  input  logic             clk,
  input  logic             rst,
  input  cfprf_pkg::req_t  item,
  input  logic             adv,
  output logic             res_valid,
  output cfprf_pkg::rsp_t  res
);

  localparam int PB = cfprf_pkg::PAGE_INDEX_BITS;
  localparam int CB = cfprf_pkg::COUNT_BITS;

  logic [CB-1:0] run_count, run_count_next;
  logic [PB-1:0] run_base, run_base_next;
  logic [PB-1:0] next_expected, next_expected_next;
  logic          search_done, search_done_next;
  logic [CB-1:0] wanted, wanted_next;
  logic [1:0]    search_unit, search_unit_next;

  logic [CB-1:0] eff_count;
  logic [PB-1:0] eff_base;
  logic [PB-1:0] eff_next;
  logic          eff_done;
  logic [1:0]    lvl;
  logic [CB-1:0] weight;
  logic [CB:0]   sum;
  logic [CB-1:0] new_count;
  logic [PB-1:0] step_idx;
  logic          restart;
  cfprf_pkg::cls_t cls;

  // A first entry starts from a clean run
  always_comb begin
    eff_count        = item.first_entry ? '0 : run_count;
    eff_base         = item.first_entry ? '0 : run_base;
    eff_next         = item.first_entry ? '0 : next_expected;
    eff_done         = item.first_entry ? 1'b0 : search_done;
    wanted_next      = item.first_entry ? item.pages_wanted : wanted;
    search_unit_next = item.first_entry ? cfprf_pkg::sat_level(item.unit) : search_unit;
    lvl              = cfprf_pkg::sat_level(item.level);
  end

  cfprf_classify u_classify (
    .unit             (search_unit_next),
    .level            (lvl),
    .state_code       (item.state_code),
    .has_subtable     (item.has_subtable),
    .buddy_owned      (item.buddy_owned),
    .entry_missing    (item.entry_missing),
    .children_missing (item.children_missing),
    .cls              (cls)
  );

  // Run length arithmetic
  always_comb begin
    weight    = cfprf_pkg::weight_of(lvl - search_unit_next);
    sum       = {1'b0, eff_count} + {1'b0, weight};
    restart   = (eff_count == '0) || (item.page_index != eff_next);
    step_idx  = item.page_index + cfprf_pkg::size_of(lvl);
    if (restart) begin
      new_count = weight;
    end else if (sum[CB]) begin
      new_count = cfprf_pkg::COUNT_MAX;
    end else begin
      new_count = sum[CB-1:0];
    end
  end

  // Next state and result
  always_comb begin
    run_count_next     = eff_count;
    run_base_next      = eff_base;
    next_expected_next = eff_next;
    search_done_next   = eff_done;
    res_valid          = 1'b0;
    res.status         = cfprf_pkg::STS_FOUND;
    res.base_page      = '0;
    if (!eff_done) begin
      case (cls.act)
        cfprf_pkg::ACT_FATAL: begin
          search_done_next = 1'b1;
          res_valid        = 1'b1;
          res.status       = cls.fatal;
        end
        cfprf_pkg::ACT_FREE: begin
          run_count_next     = new_count;
          run_base_next      = restart ? item.page_index : eff_base;
          next_expected_next = step_idx;
          if (new_count >= wanted_next) begin
            search_done_next = 1'b1;
            res_valid        = 1'b1;
            res.base_page    = restart ? item.page_index : eff_base;
          end
        end
        cfprf_pkg::ACT_BREAK: begin
          run_count_next     = '0;
          next_expected_next = step_idx;
        end
        default: begin
        end
      endcase
      // segment ends without a match
      if (!res_valid && item.last_entry) begin
        search_done_next = 1'b1;
        res_valid        = 1'b1;
        res.status       = cfprf_pkg::STS_NOT_ENOUGH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count     <= '0;
      run_base      <= '0;
      next_expected <= '0;
      search_done   <= 1'b1;
      wanted        <= '0;
      search_unit   <= cfprf_pkg::LVL_4K;
    end else if (adv) begin
      run_count     <= run_count_next;
      run_base      <= run_base_next;
      next_expected <= next_expected_next;
      search_done   <= search_done_next;
      wanted        <= wanted_next;
      search_unit   <= search_unit_next;
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] ST_OTHER     = 3'd7;
  localparam logic [1:0] LVL_ALIAS_1G = 2'd3;
  localparam int HOLD_CYCLES  = 120;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 10;

  // Mirrors the open search and queues the results it should raise
  class free_run_tracker;
    logic [cfprf_pkg::COUNT_BITS-1:0]      run_len;
    logic [cfprf_pkg::PAGE_INDEX_BITS-1:0] run_start;
    logic [cfprf_pkg::PAGE_INDEX_BITS-1:0] next_page;
    logic                                  idle;
    logic [cfprf_pkg::COUNT_BITS-1:0]      target;
    logic [1:0]                            gran;
    cfprf_pkg::rsp_t                       expected_results[$];
    int                                    mismatches;

    function new();
      run_len    = '0;
      run_start  = '0;
      next_page  = '0;
      idle       = 1'b1;
      target     = '0;
      gran       = cfprf_pkg::LVL_4K;
      mismatches = 0;
    endfunction

    // Size of an entry in 4KB pages; code 3 counts as 1GB
    function logic [cfprf_pkg::PAGE_INDEX_BITS-1:0] span_of(input logic [1:0] lvl);
      logic [cfprf_pkg::PAGE_INDEX_BITS-1:0] s;
      s = 1;
      return s << (cfprf_pkg::FANOUT_SHIFT *
                   ((lvl > cfprf_pkg::LVL_1G) ? cfprf_pkg::LVL_1G : lvl));
    endfunction

    // What one descriptor does to the open search
    function cfprf_pkg::act_t judge(input cfprf_pkg::req_t d, input logic [1:0] lvl,
                                    output cfprf_pkg::status_t why);
      logic used;
      used = d.state_code inside {[cfprf_pkg::ST_KERNEL:cfprf_pkg::ST_PERSIST]};
      why = cfprf_pkg::STS_FOUND;
      if (lvl < gran) return cfprf_pkg::ACT_SKIP;
      // absent top entry: fatal only at 4KB, otherwise the gap restarts the run
      if (d.entry_missing) begin
        if (gran != cfprf_pkg::LVL_4K) return cfprf_pkg::ACT_SKIP;
        why = cfprf_pkg::STS_MISSING_TOP;
        return cfprf_pkg::ACT_FATAL;
      end
      if (lvl == cfprf_pkg::LVL_4K) begin
        if (d.has_subtable) begin
          why = cfprf_pkg::STS_4K_SUB;
          return cfprf_pkg::ACT_FATAL;
        end
        if (d.state_code == cfprf_pkg::ST_FREE) return cfprf_pkg::ACT_FREE;
        if (used || d.buddy_owned) return cfprf_pkg::ACT_BREAK;
        why = cfprf_pkg::STS_ILLEGAL;
        return cfprf_pkg::ACT_FATAL;
      end
      // atomic coarse entry
      if (!d.has_subtable && !d.buddy_owned) begin
        if (d.state_code == cfprf_pkg::ST_FREE) return cfprf_pkg::ACT_FREE;
        if (used) return cfprf_pkg::ACT_BREAK;
        if (gran == cfprf_pkg::LVL_2M && lvl == cfprf_pkg::LVL_2M &&
            d.state_code == cfprf_pkg::ST_SPLIT) return cfprf_pkg::ACT_BREAK;
        why = cfprf_pkg::STS_ILLEGAL;
        return cfprf_pkg::ACT_FATAL;
      end
      if (d.state_code == cfprf_pkg::ST_FULL || d.buddy_owned) return cfprf_pkg::ACT_BREAK;
      // split entry: children follow unless it is at the search granularity
      if (d.state_code == cfprf_pkg::ST_SPLIT) begin
        if (lvl == gran) return cfprf_pkg::ACT_BREAK;
        if (!d.children_missing) return cfprf_pkg::ACT_SKIP;
        why = cfprf_pkg::STS_MISSING_SUB;
        return cfprf_pkg::ACT_FATAL;
      end
      why = cfprf_pkg::STS_ILLEGAL;
      return cfprf_pkg::ACT_FATAL;
    endfunction

    // Takes one accepted request; returns 0 when the block ignores it
    function bit note_descriptor(input cfprf_pkg::req_t d);
      logic [1:0]                       lvl;
      cfprf_pkg::act_t                  act;
      cfprf_pkg::status_t               why;
      logic [cfprf_pkg::COUNT_BITS:0]   sum;
      logic [cfprf_pkg::COUNT_BITS-1:0] w;
      cfprf_pkg::rsp_t                  r;
      if (d.first_entry) begin
        run_len   = '0;
        run_start = '0;
        next_page = '0;
        target    = d.pages_wanted;
        gran      = (d.unit > cfprf_pkg::LVL_1G) ? cfprf_pkg::LVL_1G : d.unit;
        idle      = 1'b0;
      end
      if (idle) return 1'b0;
      lvl = (d.level > cfprf_pkg::LVL_1G) ? cfprf_pkg::LVL_1G : d.level;
      act = judge(d, lvl, why);
      r.status    = cfprf_pkg::STS_FOUND;
      r.base_page = '0;
      case (act)
        cfprf_pkg::ACT_FATAL: begin
          idle     = 1'b1;
          r.status = why;
          expected_results.push_back(r);
          return 1'b1;
        end
        cfprf_pkg::ACT_FREE: begin
          w = 1;
          w = w << (cfprf_pkg::FANOUT_SHIFT * (lvl - gran));
          if (run_len == '0 || d.page_index != next_page) begin
            run_start = d.page_index;
            run_len   = w;
          end else begin
            // saturating add
            sum = run_len + w;
            run_len = (sum > cfprf_pkg::COUNT_MAX) ? cfprf_pkg::COUNT_MAX
                                                   : sum[cfprf_pkg::COUNT_BITS-1:0];
          end
          next_page = d.page_index + span_of(lvl);
          if (run_len >= target) begin
            idle        = 1'b1;
            r.base_page = run_start;
            expected_results.push_back(r);
            return 1'b1;
          end
        end
        cfprf_pkg::ACT_BREAK: begin
          run_len   = '0;
          next_page = d.page_index + span_of(lvl);
        end
        default: ;
      endcase
      // segment ended with the search still open
      if (d.last_entry) begin
        idle     = 1'b1;
        r.status = cfprf_pkg::STS_NOT_ENOUGH;
        expected_results.push_back(r);
      end
      return 1'b1;
    endfunction

    function void check_result(input cfprf_pkg::rsp_t got);
      cfprf_pkg::rsp_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d base %h",
                 $time, got.status, got.base_page);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.base_page !== want.base_page) begin
        $display("%0t: base_page expected %h actual %h",
                 $time, want.base_page, got.base_page);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  cfprf_pkg::req_t req_data;
  logic rsp_valid;
  logic rsp_stall;
  cfprf_pkg::rsp_t rsp_data;

  free_run_tracker tracker = new();
  int live_items   = 0;
  int quiet_cycles = 0;
  bit calm         = 1'b0;
  bit long_hold    = 1'b0;

  contiguous_free_page_run_finder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Observe both channels at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall && tracker.note_descriptor(req_data))
        live_items <= live_items + 1;
      if (rsp_valid && !rsp_stall) tracker.check_result(rsp_data);
      quiet_cycles <= ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) ?
                      0 : quiet_cycles + 1;
    end
  end

  // Hang detection
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Result side back-pressure: random bursts, plus one long hold on request
  initial begin
    int hold;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      hold = 0;
      if (long_hold) begin
        hold = HOLD_CYCLES;
        long_hold <= 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 6) == 0) begin
        hold = $urandom_range(1, 14);
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
    end
  end

  function automatic cfprf_pkg::req_t descriptor(
      input logic first, input logic [1:0] u,
      input logic [cfprf_pkg::COUNT_BITS-1:0] want,
      input logic [1:0] lvl,
      input logic [cfprf_pkg::PAGE_INDEX_BITS-1:0] pg,
      input logic [2:0] st, input logic closes);
    cfprf_pkg::req_t d;
    d = '0;
    d.first_entry  = first;
    d.unit         = u;
    d.pages_wanted = want;
    d.level        = lvl;
    d.page_index   = pg;
    d.state_code   = st;
    d.last_entry   = closes;
    return d;
  endfunction

  // Offer one request, with an optional gap first, and hold it until taken
  task automatic send(input cfprf_pkg::req_t d);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= d;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(negedge clk); while (tracker.expected_results.size() != 0);
    @(posedge clk);
  endtask

  // One walk over a segment: mostly free entries, with breaks, gaps and splits
  task automatic random_search(input bit tidy);
    cfprf_pkg::req_t                       d;
    logic [1:0]                            u;
    logic [1:0]                            ue;
    logic [1:0]                            lvl;
    logic [cfprf_pkg::COUNT_BITS-1:0]      want;
    logic [cfprf_pkg::PAGE_INDEX_BITS-1:0] pg;
    int                                    n;
    int                                    pick;
    u  = ($urandom_range(0, 15) == 0) ? LVL_ALIAS_1G : 2'($urandom_range(0, 2));
    ue = (u == LVL_ALIAS_1G) ? cfprf_pkg::LVL_1G : u;
    pick = $urandom_range(0, 9);
    if (pick < 6) want = $urandom_range(1, 6);
    else if (pick < 9) want = $urandom_range(1, 1100);
    else want = cfprf_pkg::COUNT_BITS'({$urandom, $urandom});
    pg = cfprf_pkg::PAGE_INDEX_BITS'({$urandom, $urandom});
    pg[17:0] = '0;
    // top of the address space, so the run wraps
    if ($urandom_range(0, 7) == 0) pg[cfprf_pkg::PAGE_INDEX_BITS-1:18] = '1;
    n = $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      lvl = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3))
                                        : 2'($urandom_range(ue, 2));
      d = descriptor(k == 0, u, cfprf_pkg::COUNT_BITS'({$urandom, $urandom}), lvl, pg,
                     cfprf_pkg::ST_FREE, tidy && (k == n - 1));
      if (k == 0) d.pages_wanted = want;
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        // plain free entry
      end else if (pick < 68) begin
        d.state_code  = 3'($urandom_range(cfprf_pkg::ST_KERNEL, cfprf_pkg::ST_PERSIST));
        d.buddy_owned = 1'($urandom);
      end else if (pick < 73) begin
        d.state_code   = cfprf_pkg::ST_FULL;
        d.has_subtable = 1'b1;
      end else if (pick < 78) begin
        d.state_code  = 3'($urandom);
        d.buddy_owned = 1'b1;
      end else if (pick < 86) begin
        d.state_code       = cfprf_pkg::ST_SPLIT;
        d.has_subtable     = 1'b1;
        d.children_missing = ($urandom_range(0, 9) == 0);
      end else if (pick < 93) begin
        pg = pg + tracker.span_of(lvl) * $urandom_range(1, 3);
        d.page_index = pg;
      end else if (pick < 96) begin
        d.entry_missing = 1'b1;
      end else begin
        d.state_code       = 3'($urandom);
        d.has_subtable     = 1'($urandom);
        d.buddy_owned      = 1'($urandom);
        d.children_missing = 1'($urandom);
      end
      // a split above the unit is passed over: its children start at the same page
      if (!(d.state_code == cfprf_pkg::ST_SPLIT && d.has_subtable && lvl > ue))
        pg = pg + tracker.span_of(lvl);
      send(d);
    end
  endtask

  task automatic stray_items();
    cfprf_pkg::req_t d;
    repeat ($urandom_range(1, 3)) begin
      d = descriptor(1'($urandom), 2'($urandom),
                     cfprf_pkg::COUNT_BITS'({$urandom, $urandom}),
                     2'($urandom), cfprf_pkg::PAGE_INDEX_BITS'({$urandom, $urandom}),
                     3'($urandom), 1'($urandom));
      d.has_subtable     = 1'($urandom);
      d.buddy_owned      = 1'($urandom);
      d.entry_missing    = 1'($urandom);
      d.children_missing = 1'($urandom);
      send(d);
    end
  endtask

  initial begin
    cfprf_pkg::req_t d;
    int   start;
    int   progress;
    int   pick;
    bit   hold_done;
    bit   drain_done;
    rst       = 1'b1;
    req_valid = 1'b0;
    req_data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // three adjacent free 4KB pages
    send(descriptor(1, cfprf_pkg::LVL_4K, 3, cfprf_pkg::LVL_4K, 36'h100,
                    cfprf_pkg::ST_FREE, 0));
    send(descriptor(0, cfprf_pkg::LVL_4K, 0, cfprf_pkg::LVL_4K, 36'h101,
                    cfprf_pkg::ST_FREE, 0));
    send(descriptor(0, cfprf_pkg::LVL_4K, 0, cfprf_pkg::LVL_4K, 36'h102,
                    cfprf_pkg::ST_FREE, 0));
    // run carried across the address wrap
    send(descriptor(1, cfprf_pkg::LVL_4K, 2, cfprf_pkg::LVL_4K, '1, cfprf_pkg::ST_FREE, 0));
    send(descriptor(0, cfprf_pkg::LVL_4K, 0, cfprf_pkg::LVL_4K, '0, cfprf_pkg::ST_FREE, 1));
    // missing top entry at 4KB
    d = descriptor(1, cfprf_pkg::LVL_4K, 1, cfprf_pkg::LVL_4K, 36'h0, cfprf_pkg::ST_FREE, 0);
    d.entry_missing = 1'b1;
    send(d);
    // missing entry skipped at 2MB; one free 1GB entry falls short
    d = descriptor(1, cfprf_pkg::LVL_2M, 1000, cfprf_pkg::LVL_1G, 36'h4_0000,
                   cfprf_pkg::ST_FREE, 0);
    d.entry_missing = 1'b1;
    send(d);
    send(descriptor(0, cfprf_pkg::LVL_2M, 0, cfprf_pkg::LVL_1G, 36'h8_0000,
                    cfprf_pkg::ST_FREE, 1));
    // finer entry ignored, then a split 1GB entry without its subtable
    send(descriptor(1, cfprf_pkg::LVL_2M, 4, cfprf_pkg::LVL_4K, 36'h1234,
                    cfprf_pkg::ST_FREE, 0));
    d = descriptor(0, cfprf_pkg::LVL_2M, 0, cfprf_pkg::LVL_1G, 36'hC_0000,
                   cfprf_pkg::ST_SPLIT, 0);
    d.has_subtable     = 1'b1;
    d.children_missing = 1'b1;
    send(d);
    // 4KB entry claiming a subtable
    d = descriptor(1, cfprf_pkg::LVL_4K, 1, cfprf_pkg::LVL_4K, 36'h55, cfprf_pkg::ST_FREE, 0);
    d.has_subtable = 1'b1;
    send(d);
    // unknown state at 4KB
    send(descriptor(1, cfprf_pkg::LVL_4K, 1, cfprf_pkg::LVL_4K, 36'h56, ST_OTHER, 0));
    // unit and level code 3 act as 1GB
    send(descriptor(1, LVL_ALIAS_1G, 1, LVL_ALIAS_1G, 36'hF_FFFC_0000,
                    cfprf_pkg::ST_FREE, 0));
    // zero request: first counted free entry completes it
    send(descriptor(1, cfprf_pkg::LVL_4K, 0, cfprf_pkg::LVL_4K, 36'h200,
                    cfprf_pkg::ST_KERNEL, 0));
    send(descriptor(0, cfprf_pkg::LVL_4K, 0, cfprf_pkg::LVL_4K, 36'h201,
                    cfprf_pkg::ST_FREE, 0));
    // entry arriving with no search open
    send(descriptor(0, cfprf_pkg::LVL_4K, 0, cfprf_pkg::LVL_4K, 36'h202,
                    cfprf_pkg::ST_FREE, 1));
    // atomic 2MB split at 2MB unit breaks the run
    send(descriptor(1, cfprf_pkg::LVL_2M, 2, cfprf_pkg::LVL_2M, 36'h400,
                    cfprf_pkg::ST_FREE, 0));
    send(descriptor(0, cfprf_pkg::LVL_2M, 0, cfprf_pkg::LVL_2M, 36'h600,
                    cfprf_pkg::ST_SPLIT, 0));
    send(descriptor(0, cfprf_pkg::LVL_2M, 0, cfprf_pkg::LVL_2M, 36'h800,
                    cfprf_pkg::ST_FREE, 1));
    // request for 2^36 units, far more than one 1GB entry gives
    send(descriptor(1, cfprf_pkg::LVL_1G, 37'h10_0000_0000, cfprf_pkg::LVL_1G, 36'h0,
                    cfprf_pkg::ST_FREE, 1));
    // buddy-owned page breaks, then an address gap restarts the run
    d = descriptor(1, cfprf_pkg::LVL_4K, 2, cfprf_pkg::LVL_4K, 36'h10, cfprf_pkg::ST_FULL, 0);
    d.buddy_owned = 1'b1;
    send(d);
    send(descriptor(0, cfprf_pkg::LVL_4K, 0, cfprf_pkg::LVL_4K, 36'h11,
                    cfprf_pkg::ST_FREE, 0));
    send(descriptor(0, cfprf_pkg::LVL_4K, 0, cfprf_pkg::LVL_4K, 36'h13,
                    cfprf_pkg::ST_FREE, 0));
    send(descriptor(0, cfprf_pkg::LVL_4K, 0, cfprf_pkg::LVL_4K, 36'h14,
                    cfprf_pkg::ST_FREE, 1));
    wait_drained();

    // random searches in phases of gappy and gap-free traffic
    start      = live_items;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    for (int s = 0; live_items - start < RANDOM_ITEMS; s++) begin
      progress = live_items - start;
      if (!hold_done && progress >= 200) begin
        hold_done = 1'b1;
        long_hold <= 1'b1;
        calm      <= 1'b1;
      end else if (progress > RANDOM_ITEMS - 80) begin
        calm <= 1'b1;
      end else if (s % 8 == 0) begin
        calm <= ($urandom_range(0, 2) == 0);
      end
      if (!drain_done && progress >= 380) begin
        drain_done = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 19);
      if (pick < 16) random_search(1'b1);
      else if (pick < 19) random_search(1'b0);
      else stray_items();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### contiguous_free_page_run_finder_unit.f
+incdir+rtl
rtl/cfprf_pkg.sv
rtl/cfprf_classify.sv
rtl/cfprf_tracker.sv
rtl/contiguous_free_page_run_finder_unit.sv
tb/sv/tb_top.sv
